// ----- rtl/rclpf_pkg.sv -----
// shared types and constants for the rc low-pass filter
`default_nettype none

package rclpf_pkg;

  localparam int CUT_W   = 24;
  localparam int ALPHA_W = 17;
  localparam int DT_W    = 20;
  localparam int REQ_W   = 2;
  localparam int X_W     = DT_W + CUT_W;
  localparam int D_W     = X_W + 1;
  localparam int REM_W   = D_W + 1;
  localparam int CFG_W   = 1;
  localparam int CNT_W   = 5;

  localparam int DIV_STEPS = ALPHA_W - 1;
  localparam int MUL_STEPS = ALPHA_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [D_W-1:0]     RC_SCALE  = 45'd256000000;

  localparam logic [REQ_W-1:0] REQ_TIMED = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PLAIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd2;

  localparam logic [CFG_W-1:0] CFG_CUTOFF = 1'd0;
  localparam logic [CFG_W-1:0] CFG_PRESET = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_ADDD,
    ST_DIV,
    ST_DIFF,
    ST_NEG,
    ST_MUL,
    ST_FIN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    state_t st;
    logic   accept;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/rc_low_pass_filter.sv -----
// top level of the first-order rc low-pass filter
`default_nettype none

// First-order RC low-pass filter on signed samples. One result beat per input
// beat. All arithmetic but the interval times cutoff product runs through one
// shared add/subtract unit under a small sequencer, so the block takes one item
// at a time: a timed sample goes through the multiply, a 16-step restoring
// divide for alpha and a 17-step shift-add multiply for the update; a plain
// sample skips the multiply and the divide; a bypassed timed sample, an output
// load or an unused request code goes straight to the write state. A finished
// result sits in the output register while the next beat is accepted.
// Configuration writes take effect at once and must only be made while the block is idle.

module rc_low_pass_filter #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rclpf_pkg::CFG_W-1:0]         cfg_index,
  input  wire logic [rclpf_pkg::CUT_W-1:0]         cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rclpf_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  wire logic [rclpf_pkg::DT_W-1:0]          in_dt_us,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]           out_filtered,
  output logic [rclpf_pkg::ALPHA_W-1:0]            out_alpha_used
);

  rclpf_pkg::ctrl_t                   ctrl;
  logic                               bypass;
  logic                               out_free;
  logic                               out_load;
  logic signed [SAMPLE_WIDTH-1:0]     filtered;
  logic [rclpf_pkg::ALPHA_W-1:0]      alpha_used;
  logic                               out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0]     out_filtered_r;
  logic [rclpf_pkg::ALPHA_W-1:0]      out_alpha_r;

  assign out_free = !out_valid_r || out_ready;

  rclpf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .bypass      (bypass),
    .out_free    (out_free),
    .in_ready    (in_ready),
    .out_load    (out_load),
    .ctrl        (ctrl)
  );

  rclpf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_req_type (in_req_type),
    .in_sample   (in_sample),
    .in_dt_us    (in_dt_us),
    .ctrl        (ctrl),
    .bypass      (bypass),
    .filtered    (filtered),
    .alpha_used  (alpha_used)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered_r <= filtered;
      out_alpha_r    <= alpha_used;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filtered_r;
  assign out_alpha_used = out_alpha_r;

endmodule

`default_nettype wire

// ----- rtl/rclpf_ctrl.sv -----
// sequencer for the shared add/subtract unit
`default_nettype none

module rclpf_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [rclpf_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic                          bypass,
  input  wire logic                          out_free,
  output logic                               in_ready,
  output logic                               out_load,
  output rclpf_pkg::ctrl_t                   ctrl
);

  rclpf_pkg::state_t               st_r, st_nxt;
  logic [rclpf_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= rclpf_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = '0;
    case (st_r)
      rclpf_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            rclpf_pkg::REQ_TIMED: st_nxt = bypass ? rclpf_pkg::ST_WRITE : rclpf_pkg::ST_MULX;
            rclpf_pkg::REQ_PLAIN: st_nxt = rclpf_pkg::ST_DIFF;
            default:              st_nxt = rclpf_pkg::ST_WRITE;
          endcase
        end
      end
      rclpf_pkg::ST_MULX: st_nxt = rclpf_pkg::ST_ADDD;
      rclpf_pkg::ST_ADDD: st_nxt = rclpf_pkg::ST_DIV;
      rclpf_pkg::ST_DIV: begin
        if (cnt_r == rclpf_pkg::CNT_W'(rclpf_pkg::DIV_STEPS - 1)) begin
          st_nxt = rclpf_pkg::ST_DIFF;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rclpf_pkg::ST_DIFF: st_nxt = rclpf_pkg::ST_NEG;
      rclpf_pkg::ST_NEG:  st_nxt = rclpf_pkg::ST_MUL;
      rclpf_pkg::ST_MUL: begin
        if (cnt_r == rclpf_pkg::CNT_W'(rclpf_pkg::MUL_STEPS - 1)) begin
          st_nxt = rclpf_pkg::ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rclpf_pkg::ST_FIN: st_nxt = rclpf_pkg::ST_WRITE;
      rclpf_pkg::ST_WRITE: begin
        if (out_free) begin
          st_nxt = rclpf_pkg::ST_IDLE;
        end
      end
      default: st_nxt = rclpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (st_r == rclpf_pkg::ST_IDLE);
    out_load    = (st_r == rclpf_pkg::ST_WRITE) && out_free;
    ctrl.st     = st_r;
    ctrl.accept = (st_r == rclpf_pkg::ST_IDLE) && in_valid;
  end

endmodule

`default_nettype wire

// ----- rtl/rclpf_dp.sv -----
// filter state, configuration registers and the shared add/subtract unit
`default_nettype none

module rclpf_dp #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [rclpf_pkg::CFG_W-1:0]          cfg_index,
  input  wire logic [rclpf_pkg::CUT_W-1:0]          cfg_wdata,
  input  wire logic [rclpf_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  input  wire logic [rclpf_pkg::DT_W-1:0]           in_dt_us,
  input  wire rclpf_pkg::ctrl_t                     ctrl,
  output logic                                      bypass,
  output logic signed [SAMPLE_WIDTH-1:0]            filtered,
  output logic [rclpf_pkg::ALPHA_W-1:0]             alpha_used
);

  localparam int DW = SAMPLE_WIDTH + 1;
  localparam int PW = DW + rclpf_pkg::ALPHA_W;
  localparam int UW = (PW > rclpf_pkg::REM_W) ? PW : rclpf_pkg::REM_W;
  localparam int AW = rclpf_pkg::ALPHA_W;

  logic [rclpf_pkg::CUT_W-1:0]       cutoff_r;
  logic [AW-1:0]                     preset_r;
  logic [rclpf_pkg::REQ_W-1:0]       req_r;
  logic signed [SAMPLE_WIDTH-1:0]    s_r;
  logic [rclpf_pkg::DT_W-1:0]        dt_r;
  logic signed [SAMPLE_WIDTH-1:0]    o_r;
  logic [AW-1:0]                     acur_r;
  logic                              flag_r;
  logic [AW-1:0]                     used_r;
  logic [rclpf_pkg::X_W-1:0]         x_r;
  logic [rclpf_pkg::D_W-1:0]         den_r;
  logic [rclpf_pkg::D_W-1:0]         rem_r;
  logic [AW-2:0]                     q_r;
  logic signed [DW-1:0]              d_r;
  logic                              neg_r;
  logic [DW-1:0]                     mag_r;
  logic [AW-1:0]                     mq_r;
  logic [UW-1:0]                     acc_r;

  logic [UW-1:0]                     op_a, op_b;
  logic                              op_sub;
  logic [UW:0]                       res;
  logic                              ge;
  logic [AW-1:0]                     plain_alpha;
  logic [DW-1:0]                     step;

  // shared adder
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (ctrl.st)
      rclpf_pkg::ST_ADDD: begin
        op_a = UW'(x_r);
        op_b = UW'(rclpf_pkg::RC_SCALE);
      end
      rclpf_pkg::ST_DIV: begin
        op_a   = UW'({rem_r, 1'b0});
        op_b   = UW'(den_r);
        op_sub = 1'b1;
      end
      rclpf_pkg::ST_DIFF: begin
        op_a   = UW'(s_r);
        op_b   = UW'(o_r);
        op_sub = 1'b1;
      end
      rclpf_pkg::ST_NEG: begin
        op_b   = UW'(d_r);
        op_sub = 1'b1;
      end
      rclpf_pkg::ST_MUL: begin
        op_a = {acc_r[UW-2:0], 1'b0};
        op_b = mq_r[AW-1] ? UW'(mag_r) : '0;
      end
      rclpf_pkg::ST_FIN: begin
        op_a   = UW'(o_r);
        op_b   = UW'(step);
        op_sub = neg_r;
      end
      default: begin
        op_a = '0;
      end
    endcase
    res = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (UW+1)'(op_sub);
  end

  assign ge     = res[UW];
  assign step   = acc_r[(AW-1) +: DW];
  assign bypass = (cutoff_r == '0) || (in_dt_us == '0);

  always_comb begin
    plain_alpha = flag_r ? acur_r : preset_r;
    if (plain_alpha > rclpf_pkg::ALPHA_ONE) begin
      plain_alpha = rclpf_pkg::ALPHA_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
      preset_r <= rclpf_pkg::ALPHA_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rclpf_pkg::CFG_CUTOFF: cutoff_r <= cfg_wdata;
        rclpf_pkg::CFG_PRESET: preset_r <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_r    <= '0;
      acur_r <= rclpf_pkg::ALPHA_ONE;
      flag_r <= 1'b0;
    end else begin
      case (ctrl.st)
        rclpf_pkg::ST_IDLE: begin
          if (ctrl.accept) begin
            if ((in_req_type == rclpf_pkg::REQ_TIMED && bypass) ||
                in_req_type == rclpf_pkg::REQ_LOAD) begin
              o_r <= in_sample;
            end
          end
        end
        rclpf_pkg::ST_DIFF: begin
          if (req_r == rclpf_pkg::REQ_TIMED) begin
            acur_r <= AW'(q_r);
            flag_r <= 1'b1;
          end
        end
        rclpf_pkg::ST_FIN: o_r <= res[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl.st)
      rclpf_pkg::ST_IDLE: begin
        if (ctrl.accept) begin
          req_r <= in_req_type;
          s_r   <= in_sample;
          dt_r  <= in_dt_us;
          case (in_req_type)
            rclpf_pkg::REQ_TIMED: used_r <= rclpf_pkg::ALPHA_ONE;
            rclpf_pkg::REQ_PLAIN: used_r <= plain_alpha;
            default:              used_r <= '0;
          endcase
        end
      end
      rclpf_pkg::ST_MULX: x_r <= dt_r * cutoff_r;
      rclpf_pkg::ST_ADDD: begin
        den_r <= res[rclpf_pkg::D_W-1:0];
        rem_r <= rclpf_pkg::D_W'(x_r);
        q_r   <= '0;
      end
      rclpf_pkg::ST_DIV: begin
        rem_r <= ge ? res[rclpf_pkg::D_W-1:0] : {rem_r[rclpf_pkg::D_W-2:0], 1'b0};
        q_r   <= {q_r[AW-3:0], ge};
      end
      rclpf_pkg::ST_DIFF: begin
        d_r <= res[DW-1:0];
        if (req_r == rclpf_pkg::REQ_TIMED) begin
          used_r <= AW'(q_r);
        end
      end
      rclpf_pkg::ST_NEG: begin
        neg_r <= d_r[DW-1];
        mag_r <= d_r[DW-1] ? res[DW-1:0] : d_r;
        mq_r  <= used_r;
        acc_r <= '0;
      end
      rclpf_pkg::ST_MUL: begin
        acc_r <= res[UW-1:0];
        mq_r  <= {mq_r[AW-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  assign filtered   = o_r;
  assign alpha_used = used_r;

endmodule

`default_nettype wire

// ----- rtl/rclpf_chk.sv -----
// port-level checks for the rc low-pass filter, bound to the top level
`default_nettype none

module rclpf_chk #(
  parameter int SAMPLE_WIDTH = 24
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [rclpf_pkg::REQ_W-1:0]         in_req_type,
  input wire logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input wire logic [rclpf_pkg::DT_W-1:0]          in_dt_us,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [SAMPLE_WIDTH-1:0]      out_filtered,
  input wire logic [rclpf_pkg::ALPHA_W-1:0]       out_alpha_used
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered) &&
      $stable(out_alpha_used))
    else $error("result beat changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha_used <= rclpf_pkg::ALPHA_ONE)
    else $error("alpha above one");

  // output load reaches the output through the write state and the output register
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == rclpf_pkg::REQ_LOAD &&
      (!out_valid || out_ready)
    |=> ##1 out_valid && out_filtered == $past(in_sample, 2) && out_alpha_used == '0)
    else $error("output load result wrong");

  // zero interval passes the sample through
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == rclpf_pkg::REQ_TIMED && in_dt_us == '0 &&
      (!out_valid || out_ready)
    |=> ##1 out_valid && out_filtered == $past(in_sample, 2) &&
      out_alpha_used == rclpf_pkg::ALPHA_ONE)
    else $error("zero interval result wrong");

endmodule

bind rc_low_pass_filter rclpf_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_req_type    (in_req_type),
  .in_sample      (in_sample),
  .in_dt_us       (in_dt_us),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_filtered   (out_filtered),
  .out_alpha_used (out_alpha_used)
);

`default_nettype wire
